### hdl/cpa_pkg.sv
package cpa_pkg;

  localparam int unsigned AIRTIME_W   = 28;
  localparam int unsigned BW_W        = 19;
  localparam int unsigned SYM_W       = 14;
  localparam int unsigned PROD_W      = 34;
  localparam int unsigned SHIFT_W     = 49;
  localparam int unsigned QUOT1_W     = 10;
  localparam int unsigned DIV1_W      = 4;
  localparam logic [AIRTIME_W-1:0] AIRTIME_MAX = {AIRTIME_W{1'b1}};
  localparam logic [19:0] US_PER_S = 20'd1000000;
  localparam logic [10:0] FIXED_Q   = 11'd11;  // (28 + 16) / 4
  localparam logic [10:0] HEADER_Q  = 11'd5;   // 20 / 4

  // Side data that travels with the symbol block division.
  typedef struct packed {
    logic [3:0]      cr;
    logic            pos;
    logic [3:0]      sf;
    logic [BW_W-1:0] bw;
  } blk_side_t;

endpackage

### hdl/cpa_div_cell.sv
module cpa_div_cell
  import cpa_pkg::*;
#(
  parameter int unsigned DW = 4,
  parameter int unsigned NB = 10,
  parameter int unsigned SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          vld_i,
  input  logic [DW-1:0] rem_i,
  input  logic [NB-1:0] nq_i,
  input  logic [DW-1:0] div_i,
  input  logic [SW-1:0] sb_i,
  output logic          vld_o,
  output logic [DW-1:0] rem_o,
  output logic [NB-1:0] nq_o,
  output logic [DW-1:0] div_o,
  output logic [SW-1:0] sb_o
);

  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;
  logic [DW-1:0] rem_d;
  logic [NB-1:0] nq_d;

  // One restoring step: bring down the next numerator bit, shift in a quotient bit.
  always_comb begin
    trial = {rem_i, nq_i[NB-1]};
    diff  = trial - {1'b0, div_i};
    ge    = (trial >= {1'b0, div_i});
    rem_d = ge ? diff[DW-1:0] : trial[DW-1:0];
    nq_d  = {nq_i[NB-2:0], ge};
  end

  // Valid flag is control state and is reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_o <= 1'b0;
    end else if (en_i) begin
      vld_o <= vld_i;
    end
  end

  // The word itself moves on without reset.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o <= rem_d;
      nq_o  <= nq_d;
      div_o <= div_i;
      sb_o  <= sb_i;
    end
  end

endmodule

### hdl/chirp_packet_airtime_core.sv
// The pipeline has 41 register stages from the edge that accepts a word to the edge where its result
// can be taken: 10 + 28 divider cells, symbol, product and output.
// Throughput: one word per cycle; the chains of 10 and 28 divider cells each
// retire one quotient bit per cell while every cell holds a different word.
// The pipeline only holds while a result waits at a stalled output.
// Reset clears all valid flags asynchronously; payload registers are not reset.
module chirp_packet_airtime_core
  import cpa_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [7:0]           payload_length_i,
  input  logic [3:0]           spread_factor_i,
  input  logic                 header_explicit_i,
  input  logic                 low_rate_opt_i,
  input  logic [3:0]           rate_multiplier_i,
  input  logic [BW_W-1:0]      bandwidth_hz_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [AIRTIME_W-1:0] airtime_us_o
);

  localparam int unsigned SB1_W = $bits(blk_side_t);

  logic adv;
  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  // Front end: everything is a multiple of four, so work on n/4 and d/4.
  logic signed [10:0] n_q4;
  logic signed [5:0]  d_q4;
  logic        [10:0] m_abs;
  logic        [DIV1_W-1:0] e_abs;
  logic        [QUOT1_W-1:0] m_dec;
  blk_side_t          side0;

  always_comb begin
    n_q4 = $signed({2'b00, payload_length_i, 1'b0}) - $signed({7'd0, spread_factor_i})
           + $signed(FIXED_Q) - (header_explicit_i ? 11'sd0 : $signed(HEADER_Q));
    d_q4 = $signed({2'b00, spread_factor_i}) - $signed({4'd0, low_rate_opt_i, 1'b0});
    m_abs = d_q4[5] ? 11'(-n_q4) : 11'(n_q4);
    e_abs = d_q4[5] ? DIV1_W'(-d_q4) : d_q4[DIV1_W-1:0];
    m_dec = QUOT1_W'(m_abs - 11'd1);
    side0.cr  = rate_multiplier_i;
    side0.pos = !m_abs[10] && (m_abs != 11'd0) && (e_abs != '0);
    side0.sf  = spread_factor_i;
    side0.bw  = bandwidth_hz_i;
  end

  // First chain: floor((m-1)/e), one bit per cell.
  logic [QUOT1_W:0]             c1_vld;
  logic [DIV1_W-1:0]            c1_rem [QUOT1_W+1];
  logic [QUOT1_W-1:0]           c1_nq  [QUOT1_W+1];
  logic [DIV1_W-1:0]            c1_div [QUOT1_W+1];
  logic [SB1_W-1:0]             c1_sb  [QUOT1_W+1];

  assign c1_vld[0] = in_valid_i;
  assign c1_rem[0] = '0;
  assign c1_nq[0]  = m_dec;
  assign c1_div[0] = e_abs;
  assign c1_sb[0]  = side0;

  for (genvar i = 0; i < QUOT1_W; i++) begin : g_blk
    cpa_div_cell #(.DW(DIV1_W), .NB(QUOT1_W), .SW(SB1_W)) u_cell (
      .clk_i, .rst_ni, .en_i(adv),
      .vld_i(c1_vld[i]), .rem_i(c1_rem[i]), .nq_i(c1_nq[i]),
      .div_i(c1_div[i]), .sb_i(c1_sb[i]),
      .vld_o(c1_vld[i+1]), .rem_o(c1_rem[i+1]), .nq_o(c1_nq[i+1]),
      .div_o(c1_div[i+1]), .sb_o(c1_sb[i+1])
    );
  end

  // Symbol count.
  blk_side_t         side1;
  logic [SYM_W-1:0]  blocks;
  logic              sym_vld_q;
  logic [SYM_W-1:0]  sym_q;
  logic [3:0]        sym_sf_q;
  logic [BW_W-1:0]   sym_bw_q;
  logic              prod_vld_q;

  always_comb begin
    side1  = blk_side_t'(c1_sb[QUOT1_W]);
    blocks = (SYM_W'(c1_nq[QUOT1_W]) + SYM_W'(1)) * SYM_W'(side1.cr);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sym_vld_q  <= 1'b0;
      prod_vld_q <= 1'b0;
    end else if (adv) begin
      sym_vld_q  <= c1_vld[QUOT1_W];
      prod_vld_q <= sym_vld_q;
    end
  end

  // Scale by one million.
  logic [PROD_W-1:0] prod_q;
  logic [3:0]        prod_sf_q;
  logic [BW_W-1:0]   prod_bw_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sym_q     <= side1.pos ? (blocks + SYM_W'(8)) : SYM_W'(8);
      sym_sf_q  <= side1.sf;
      sym_bw_q  <= side1.bw;
      prod_q    <= PROD_W'(sym_q) * PROD_W'(US_PER_S);
      prod_sf_q <= sym_sf_q;
      prod_bw_q <= sym_bw_q;
    end
  end

  // Chips per symbol shift and overflow check against the bandwidth.
  logic [SHIFT_W-1:0] num;
  logic               sat;

  always_comb begin
    num = SHIFT_W'(prod_q) << prod_sf_q;
    sat = num[SHIFT_W-1:AIRTIME_W] >= (SHIFT_W-AIRTIME_W)'(prod_bw_q);
  end

  // Second chain: 28 quotient bits of num / bandwidth.
  logic [AIRTIME_W:0]      c2_vld;
  logic [BW_W-1:0]         c2_rem [AIRTIME_W+1];
  logic [AIRTIME_W-1:0]    c2_nq  [AIRTIME_W+1];
  logic [BW_W-1:0]         c2_div [AIRTIME_W+1];
  logic [0:0]              c2_sb  [AIRTIME_W+1];

  assign c2_vld[0] = prod_vld_q;
  assign c2_rem[0] = num[AIRTIME_W +: BW_W];
  assign c2_nq[0]  = num[AIRTIME_W-1:0];
  assign c2_div[0] = prod_bw_q;
  assign c2_sb[0]  = sat;

  for (genvar j = 0; j < AIRTIME_W; j++) begin : g_bw
    cpa_div_cell #(.DW(BW_W), .NB(AIRTIME_W), .SW(1)) u_cell (
      .clk_i, .rst_ni, .en_i(adv),
      .vld_i(c2_vld[j]), .rem_i(c2_rem[j]), .nq_i(c2_nq[j]),
      .div_i(c2_div[j]), .sb_i(c2_sb[j]),
      .vld_o(c2_vld[j+1]), .rem_o(c2_rem[j+1]), .nq_o(c2_nq[j+1]),
      .div_o(c2_div[j+1]), .sb_o(c2_sb[j+1])
    );
  end

  // Output register with saturation.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (adv) begin
      out_valid_o <= c2_vld[AIRTIME_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      airtime_us_o <= c2_sb[AIRTIME_W][0] ? AIRTIME_MAX : c2_nq[AIRTIME_W];
    end
  end

endmodule

### hdl/cpa_checker.sv
module cpa_checker
  import cpa_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_stall_o,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input logic [AIRTIME_W-1:0] airtime_us_o
);

  // A stalled result stays offered.
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  // A stalled result keeps its value.
  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(airtime_us_o))
    else $error("result word changed while stalled");

  // With no result waiting the block takes input.
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output");

  // Input is only held back by a stalled output.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_stall_i && out_valid_o)
    else $error("input stalled without output back pressure");

endmodule

bind chirp_packet_airtime_core cpa_checker u_cpa_checker (.*);
